### design/cvx_pkg.sv
// Package for the convex polygon checker: widths, edge direction codes,
// stage words passed between the pipeline modules. No dependencies.
`default_nettype none

package cvx_pkg;

  // Coordinate and arithmetic widths
  localparam int COORD_W     = 16;
  localparam int DIFF_W      = COORD_W + 1;       // exact coordinate difference
  localparam int PROD_W      = 2 * DIFF_W;        // exact product of two differences
  localparam int CROSS_W     = PROD_W + 1;        // exact cross product
  localparam int NUM_CORNERS = 3;

  // Corner lanes: the corner at the previous vertex, and the two corners
  // that close the polygon on its last vertex
  localparam int CORNER_MID   = 0;
  localparam int CORNER_CLOSE = 1;
  localparam int CORNER_WRAP  = 2;

  // Direction change counter saturates; more than MAX_CHANGES fails
  localparam logic [1:0] CHANGE_SAT  = 2'd3;
  localparam logic [1:0] MAX_CHANGES = 2'd2;
  localparam logic [1:0] VCOUNT_SAT  = 2'd3;

  // Lexicographic edge direction, x first then y
  typedef enum logic [1:0] {
    DIR_SAME = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // Difference operands of one corner cross product
  typedef struct packed {
    logic signed [DIFF_W-1:0] ax;
    logic signed [DIFF_W-1:0] ay;
    logic signed [DIFF_W-1:0] bx;
    logic signed [DIFF_W-1:0] by;
  } corner_ops_t;

  // Front stage word: corner operands plus the direction verdict
  typedef struct packed {
    logic [NUM_CORNERS-1:0]    corner_en;
    corner_ops_t [NUM_CORNERS-1:0] ops;
    logic                      last;
    logic                      shape_ok;
  } geom_word_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] p_ab;
    logic signed [PROD_W-1:0] p_ay_bx;
  } prod_pair_t;

  // Product stage word
  typedef struct packed {
    logic [NUM_CORNERS-1:0]       corner_en;
    prod_pair_t [NUM_CORNERS-1:0] prods;
    logic                         last;
    logic                         shape_ok;
  } prod_word_t;

  // Sign stage word: per corner negative and positive flags
  typedef struct packed {
    logic [NUM_CORNERS-1:0] neg;
    logic [NUM_CORNERS-1:0] pos;
    logic                   last;
    logic                   shape_ok;
  } sign_word_t;

  function automatic dir_t lex_dir(input logic signed [COORD_W-1:0] ax,
                                   input logic signed [COORD_W-1:0] ay,
                                   input logic signed [COORD_W-1:0] bx,
                                   input logic signed [COORD_W-1:0] by);
    dir_t d;
    if (ax < bx)      d = DIR_UP;
    else if (ax > bx) d = DIR_DOWN;
    else if (ay < by) d = DIR_UP;
    else if (ay > by) d = DIR_DOWN;
    else              d = DIR_SAME;
    return d;
  endfunction

endpackage

`default_nettype wire

### design/cvx_vertex_if.sv
// Vertex channel interface: valid/ready handshake, one vertex per word.
// Depends on cvx_pkg for the coordinate width.
`default_nettype none

interface cvx_vertex_if import cvx_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vx;
  logic signed [COORD_W-1:0] vy;
  logic                      final_vertex;

  modport source(output valid, vx, vy, final_vertex, input ready);
  modport sink(input valid, vx, vy, final_vertex, output ready);
endinterface

`default_nettype wire

### design/cvx_result_if.sv
// Result channel interface: valid/ready handshake, one verdict per word.
// No dependencies.
`default_nettype none

interface cvx_result_if;
  logic valid;
  logic ready;
  logic is_convex;

  modport source(output valid, is_convex, input ready);
  modport sink(input valid, is_convex, output ready);
endinterface

`default_nettype wire

### design/convex_polygon_check.sv
// Top level of the streaming convex polygon checker.
// Depends on cvx_pkg, cvx_vertex_if, cvx_result_if, cvx_front, cvx_cross, cvx_accum.
//
//   channel  | dir | word                              | words
//   ---------+-----+-----------------------------------+---------------------------
//   vertex   | in  | vx, vy (signed), final_vertex     | one per polygon vertex
//   result   | out | is_convex                         | one per polygon, on last
//
// One vertex is accepted per cycle unless the pipeline stalls; the pipeline is front
// register, product register, sign register and result register, and a polygon's result
// passes through them in that order once its last vertex is taken. Each stage has its
// own valid bit; while a result waits, inner vertices keep flowing, but the next
// last word holds in the sign register and the input stalls once the stages fill.
// Synchronous reset clears all valid bits and per-polygon state.
`default_nettype none

module convex_polygon_check import cvx_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  cvx_vertex_if.sink   vertex,
  cvx_result_if.source result
);

  geom_word_t geom;
  logic       geom_valid, geom_ready;
  sign_word_t signs;
  logic       sign_valid, sign_ready;

  cvx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .vertex     (vertex),
    .geom       (geom),
    .geom_valid (geom_valid),
    .geom_ready (geom_ready)
  );

  cvx_cross u_cross (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .geom_valid (geom_valid),
    .geom_ready (geom_ready),
    .signs      (signs),
    .sign_valid (sign_valid),
    .sign_ready (sign_ready)
  );

  cvx_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .signs      (signs),
    .sign_valid (sign_valid),
    .sign_ready (sign_ready),
    .result     (result)
  );

endmodule

`default_nettype wire

### design/cvx_front.sv
// Front stage: vertex history, edge direction tracking, corner operands.
// Depends on cvx_pkg and cvx_vertex_if.
`default_nettype none

module cvx_front import cvx_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  cvx_vertex_if.sink  vertex,
  output geom_word_t  geom,
  output logic        geom_valid,
  input  wire logic   geom_ready
);

  // Vertex history (payload, written before it is read in each polygon)
  logic signed [COORD_W-1:0] first_x, first_y, second_x, second_y;
  logic signed [COORD_W-1:0] prev_x, prev_y, older_x, older_y;

  // Direction tracking state
  logic [1:0] vertex_count;
  dir_t       edge_direction;
  dir_t       first_direction;
  logic [1:0] change_count;
  logic       dir_failed;

  logic       accept;
  dir_t       d_in, d_close;
  logic       mid_step, closing, fail_total;
  logic [1:0] cc1, cc2, cc3;
  dir_t       e1;
  geom_word_t geom_next;

  function automatic logic [1:0] bump(input logic [1:0] cnt, input dir_t was,
                                      input dir_t now);
    return (now != was && cnt != CHANGE_SAT) ? cnt + 2'd1 : cnt;
  endfunction

  // Differences for the corner at c, with predecessor l and successor n
  function automatic corner_ops_t make_ops(
      input logic signed [COORD_W-1:0] lx, input logic signed [COORD_W-1:0] ly,
      input logic signed [COORD_W-1:0] cx, input logic signed [COORD_W-1:0] cy,
      input logic signed [COORD_W-1:0] nx, input logic signed [COORD_W-1:0] ny);
    corner_ops_t o;
    o.ax = {nx[COORD_W-1], nx} - {cx[COORD_W-1], cx};
    o.ay = {ny[COORD_W-1], ny} - {cy[COORD_W-1], cy};
    o.bx = {lx[COORD_W-1], lx} - {cx[COORD_W-1], cx};
    o.by = {ly[COORD_W-1], ly} - {cy[COORD_W-1], cy};
    return o;
  endfunction

  assign vertex.ready = !geom_valid || geom_ready;
  assign accept       = vertex.valid && vertex.ready;

  // Directions of the incoming edge and the closing edge, and change counts
  always_comb begin
    d_in       = lex_dir(prev_x, prev_y, vertex.vx, vertex.vy);
    d_close    = lex_dir(vertex.vx, vertex.vy, first_x, first_y);
    mid_step   = vertex_count[1];
    closing    = vertex.final_vertex && mid_step;
    cc1        = mid_step ? bump(change_count, edge_direction, d_in) : change_count;
    e1         = mid_step ? d_in : edge_direction;
    cc2        = bump(cc1, e1, d_close);
    cc3        = bump(cc2, d_close, first_direction);
    fail_total = dir_failed || (vertex_count != 2'd0 && d_in == DIR_SAME) ||
                 (d_close == DIR_SAME);
  end

  // Word for the product stage
  always_comb begin
    geom_next.corner_en[CORNER_MID]   = mid_step;
    geom_next.corner_en[CORNER_CLOSE] = closing;
    geom_next.corner_en[CORNER_WRAP]  = closing;
    geom_next.ops[CORNER_MID]   = make_ops(older_x, older_y, prev_x, prev_y,
                                           vertex.vx, vertex.vy);
    geom_next.ops[CORNER_CLOSE] = make_ops(prev_x, prev_y, vertex.vx, vertex.vy,
                                           first_x, first_y);
    geom_next.ops[CORNER_WRAP]  = make_ops(vertex.vx, vertex.vy, first_x, first_y,
                                           second_x, second_y);
    geom_next.last     = vertex.final_vertex;
    geom_next.shape_ok = closing && !fail_total && (cc3 <= MAX_CHANGES);
  end

  // Direction state; cleared after the last vertex of a polygon
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count    <= 2'd0;
      edge_direction  <= DIR_SAME;
      first_direction <= DIR_SAME;
      change_count    <= 2'd0;
      dir_failed      <= 1'b0;
    end else if (accept) begin
      if (vertex.final_vertex) begin
        vertex_count    <= 2'd0;
        edge_direction  <= DIR_SAME;
        first_direction <= DIR_SAME;
        change_count    <= 2'd0;
        dir_failed      <= 1'b0;
      end else begin
        if (vertex_count != 2'd0 && d_in == DIR_SAME) dir_failed <= 1'b1;
        if (vertex_count == 2'd1) begin
          first_direction <= d_in;
          edge_direction  <= d_in;
        end else if (mid_step) begin
          change_count   <= cc1;
          edge_direction <= d_in;
        end
        if (vertex_count != VCOUNT_SAT) vertex_count <= vertex_count + 2'd1;
      end
    end
  end

  // Vertex history
  always_ff @(posedge clk) begin
    if (accept) begin
      if (vertex_count == 2'd0) begin
        first_x <= vertex.vx;
        first_y <= vertex.vy;
      end
      if (vertex_count == 2'd1) begin
        second_x <= vertex.vx;
        second_y <= vertex.vy;
      end
      older_x <= prev_x;
      older_y <= prev_y;
      prev_x  <= vertex.vx;
      prev_y  <= vertex.vy;
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) geom_valid <= 1'b0;
    else if (vertex.ready) geom_valid <= vertex.valid;
  end

  always_ff @(posedge clk) begin
    if (accept) geom <= geom_next;
  end

`ifndef SYNTHESIS
  // A polygon's last vertex leaves the tracker cleared for the next one
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && vertex.final_vertex |=> vertex_count == 2'd0 && change_count == 2'd0
    && !dir_failed)
    else $error("direction state not cleared after last vertex");

  // A passing shape verdict only comes with a closing word of a real polygon
  a_ok_only_closing: assert property (@(posedge clk) disable iff (rst)
    geom_valid && geom.shape_ok |-> geom.last && geom.corner_en[CORNER_MID]
    && geom.corner_en[CORNER_CLOSE])
    else $error("shape verdict on a non-closing word");
`endif

endmodule

`default_nettype wire

### design/cvx_cross.sv
// Cross product stages: registered products, then registered sign flags.
// Depends on cvx_pkg.
`default_nettype none

module cvx_cross import cvx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire geom_word_t  geom,
  input  wire logic        geom_valid,
  output logic             geom_ready,
  output sign_word_t       signs,
  output logic             sign_valid,
  input  wire logic        sign_ready
);

  prod_word_t prod;
  logic       prod_valid;
  logic       prod_ready;
  prod_word_t prod_next;
  sign_word_t signs_next;
  logic signed [CROSS_W-1:0] cross_val [NUM_CORNERS];

  assign geom_ready = !prod_valid || prod_ready;
  assign prod_ready = !sign_valid || sign_ready;

  // Two products per corner lane
  always_comb begin
    prod_next.corner_en = geom.corner_en;
    prod_next.last      = geom.last;
    prod_next.shape_ok  = geom.shape_ok;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      prod_next.prods[i].p_ab    = PROD_W'(geom.ops[i].ax) * PROD_W'(geom.ops[i].by);
      prod_next.prods[i].p_ay_bx = PROD_W'(geom.ops[i].ay) * PROD_W'(geom.ops[i].bx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) prod_valid <= 1'b0;
    else if (geom_ready) prod_valid <= geom_valid;
  end

  always_ff @(posedge clk) begin
    if (geom_valid && geom_ready) prod <= prod_next;
  end

  // Cross product sign per lane; disabled lanes report nothing
  always_comb begin
    signs_next.last     = prod.last;
    signs_next.shape_ok = prod.shape_ok;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      cross_val[i] = {prod.prods[i].p_ab[PROD_W-1], prod.prods[i].p_ab}
                   - {prod.prods[i].p_ay_bx[PROD_W-1], prod.prods[i].p_ay_bx};
      signs_next.neg[i] = prod.corner_en[i] && cross_val[i][CROSS_W-1];
      signs_next.pos[i] = prod.corner_en[i] && !cross_val[i][CROSS_W-1]
                          && (|cross_val[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sign_valid <= 1'b0;
    else if (prod_ready) sign_valid <= prod_valid;
  end

  always_ff @(posedge clk) begin
    if (prod_valid && prod_ready) signs <= signs_next;
  end

endmodule

`default_nettype wire

### design/cvx_accum.sv
// Per-polygon accumulation of corner signs and the result register.
// Depends on cvx_pkg and cvx_result_if.
`default_nettype none

module cvx_accum import cvx_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire sign_word_t  signs,
  input  wire logic        sign_valid,
  output logic             sign_ready,
  cvx_result_if.source     result
);

  logic neg_seen, pos_seen;
  logic fire;
  logic any_neg, any_pos;
  logic verdict;

  // Only a closing word needs room in the result register
  assign sign_ready = !signs.last || !result.valid || result.ready;
  assign fire       = sign_valid && sign_ready;

  always_comb begin
    any_neg = neg_seen || (|signs.neg);
    any_pos = pos_seen || (|signs.pos);
    verdict = signs.shape_ok && !any_neg && any_pos;
  end

  // Running flags over the polygon's corners
  always_ff @(posedge clk) begin
    if (rst) begin
      neg_seen <= 1'b0;
      pos_seen <= 1'b0;
    end else if (fire) begin
      if (signs.last) begin
        neg_seen <= 1'b0;
        pos_seen <= 1'b0;
      end else begin
        neg_seen <= any_neg;
        pos_seen <= any_pos;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (fire && signs.last) result.valid <= 1'b1;
    else if (result.ready) result.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire && signs.last) result.is_convex <= verdict;
  end

`ifndef SYNTHESIS
  // A new result only appears after a closing word was taken
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(fire && signs.last))
    else $error("result without a closing word");

  // Corner flags start fresh for each polygon
  a_flags_cleared: assert property (@(posedge clk) disable iff (rst)
    fire && signs.last |=> !neg_seen && !pos_seen)
    else $error("corner flags not cleared after polygon");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for convex_polygon_check: random and directed polygons,
// a local convexity predictor, randomized valid/ready idling and a long output stall.
// Depends on cvx_pkg, cvx_vertex_if, cvx_result_if and the design under test.
module tb import cvx_pkg::*; ();

  localparam int    HOLD_AT     = 12;    // result count that triggers the long stall
  localparam int    HOLD_CYCLES = 300;
  localparam int    RANDOM_WORDS = 650;
  localparam real   TWO_PI      = 6.283185307179586;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      fin;
    int                        gap;
  } vertex_word_t;

  logic clk = 1'b0;
  logic rst;

  cvx_vertex_if vtx_bus ();
  cvx_result_if res_bus ();

  convex_polygon_check uut (
    .clk    (clk),
    .rst    (rst),
    .vertex (vtx_bus),
    .result (res_bus)
  );

  always #1 clk = ~clk;

  vertex_word_t pending_q[$];
  bit           verdict_q[$];
  int           shape_x[$];
  int           shape_y[$];
  bit           burst;
  int           mismatches   = 0;
  int           results_seen = 0;
  int           send_wait    = 0;
  int           stall_left   = 0;
  logic         vtx_taken    = 1'b0;
  logic         res_taken    = 1'b0;

  // Predictor state for the polygon in progress
  logic signed [COORD_W-1:0] head_x, head_y, next_x, next_y;
  logic signed [COORD_W-1:0] last_x, last_y, pen_x, pen_y;
  dir_t       run_dir, open_dir;
  logic [1:0] turn_cnt, vtx_cnt;
  logic       any_left, broken;

  task automatic clear_poly();
    head_x = '0; head_y = '0; next_x = '0; next_y = '0;
    last_x = '0; last_y = '0; pen_x  = '0; pen_y  = '0;
    run_dir  = DIR_SAME;
    open_dir = DIR_SAME;
    turn_cnt = '0;
    vtx_cnt  = '0;
    any_left = 1'b0;
    broken   = 1'b0;
  endtask

  // Lexicographic order via offset-binary keys: x in the upper half, y below
  function automatic dir_t order_of(input logic signed [COORD_W-1:0] ax, ay, bx, by);
    logic [2*COORD_W-1:0] ka, kb;
    ka = {~ax[COORD_W-1], ax[COORD_W-2:0], ~ay[COORD_W-1], ay[COORD_W-2:0]};
    kb = {~bx[COORD_W-1], bx[COORD_W-2:0], ~by[COORD_W-1], by[COORD_W-2:0]};
    if (ka < kb) return DIR_UP;
    if (ka > kb) return DIR_DOWN;
    return DIR_SAME;
  endfunction

  task automatic log_turn(input dir_t d);
    if (d != run_dir && turn_cnt != CHANGE_SAT) turn_cnt = turn_cnt + 2'd1;
    run_dir = d;
  endtask

  task automatic take_side(input dir_t d);
    if (d == DIR_SAME) broken = 1'b1;
    log_turn(d);
  endtask

  // Corner turn sign; exact in CROSS_W bits
  task automatic turn_at(input logic signed [COORD_W-1:0] lx, ly, cx, cy, nx, ny);
    logic signed [CROSS_W-1:0] ax, ay, bx, by, z;
    ax = CROSS_W'(nx) - CROSS_W'(cx);
    ay = CROSS_W'(ny) - CROSS_W'(cy);
    bx = CROSS_W'(lx) - CROSS_W'(cx);
    by = CROSS_W'(ly) - CROSS_W'(cy);
    z  = ax * by - ay * bx;
    if (z < 0) broken = 1'b1;
    else if (z > 0) any_left = 1'b1;
  endtask

  task automatic predict_vertex(input logic signed [COORD_W-1:0] x, y, input logic fin);
    dir_t d;
    bit   ok;
    if (vtx_cnt == 2'd0) begin
      head_x = x;
      head_y = y;
    end else begin
      d = order_of(last_x, last_y, x, y);
      if (vtx_cnt == 2'd1) begin
        if (d == DIR_SAME) broken = 1'b1;
        open_dir = d;
        run_dir  = d;
        next_x   = x;
        next_y   = y;
      end else begin
        take_side(d);
        turn_at(pen_x, pen_y, last_x, last_y, x, y);
      end
    end
    pen_x  = last_x;
    pen_y  = last_y;
    last_x = x;
    last_y = y;
    if (vtx_cnt != VCOUNT_SAT) vtx_cnt = vtx_cnt + 2'd1;
    if (fin) begin
      ok = 1'b0;
      // close the ring: closing edge, wrap back to the first edge, two closing corners
      if (vtx_cnt == VCOUNT_SAT) begin
        take_side(order_of(last_x, last_y, head_x, head_y));
        log_turn(open_dir);
        turn_at(pen_x, pen_y, last_x, last_y, head_x, head_y);
        turn_at(last_x, last_y, head_x, head_y, next_x, next_y);
        ok = !broken && any_left && (turn_cnt <= MAX_CHANGES);
      end
      verdict_q.push_back(ok);
      clear_poly();
    end
  endtask

  // Stimulus helpers
  function automatic int clip16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rnd16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic put(input int x, input int y, input bit fin);
    vertex_word_t w;
    w.x   = COORD_W'(x);
    w.y   = COORD_W'(y);
    w.fin = fin;
    w.gap = burst ? 0 : $urandom_range(0, 4);
    pending_q.push_back(w);
  endtask

  // Points on a jittered ellipse, visited with the given stride
  task automatic make_ring(input int ox, oy, rx, ry, n, stride);
    int  px[64], py[64];
    int  k;
    real step, base, ang;
    step = TWO_PI / n;
    base = $urandom_range(0, 6283) / 1000.0;
    shape_x.delete();
    shape_y.delete();
    for (k = 0; k < n; k++) begin
      ang   = base + (k + $urandom_range(0, 700) / 1000.0) * step;
      px[k] = clip16(ox + $rtoi(rx * $cos(ang)));
      py[k] = clip16(oy + $rtoi(ry * $sin(ang)));
    end
    for (k = 0; k < n; k++) begin
      shape_x.push_back(px[(k * stride) % n]);
      shape_y.push_back(py[(k * stride) % n]);
    end
  endtask

  task automatic emit_shape(input bit backward);
    int k, j, n;
    n = shape_x.size();
    for (k = 0; k < n; k++) begin
      j = backward ? n - 1 - k : k;
      put(shape_x[j], shape_y[j], k == n - 1);
    end
  endtask

  // Stimulus, reset and end of run
  initial begin
    int n, ox, oy, rx, ry, pick, k, t;
    rst = 1'b1;
    vtx_bus.valid        = 1'b0;
    vtx_bus.vx           = '0;
    vtx_bus.vy           = '0;
    vtx_bus.final_vertex = 1'b0;
    res_bus.ready        = 1'b0;
    clear_poly();
    burst = 1'b0;

    // single vertex and two vertices: too few
    put(0, 0, 1);
    put(-32768, 32767, 0); put(32767, -32768, 1);
    // full-range counterclockwise triangle
    put(-32768, -32768, 0); put(32767, -32768, 0); put(-32768, 32767, 1);
    // clockwise triangle: reflex corners
    put(0, 0, 0); put(0, 10, 0); put(10, 0, 1);
    // collinear: no positive corner
    put(-5, -5, 0); put(0, 0, 0); put(5, 5, 1);
    // repeated vertex inside the ring
    put(0, 0, 0); put(10, 0, 0); put(10, 0, 0); put(10, 10, 1);
    // last vertex equals the first
    put(0, 0, 0); put(10, 0, 0); put(10, 10, 0); put(0, 0, 1);
    // pentagram: all left turns, winds twice
    put(0, 100, 0); put(-59, -81, 0); put(95, 31, 0); put(-95, 31, 0); put(59, -81, 1);

    // Random polygons, mostly well formed
    while (pending_q.size() < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 5) == 0);
      pick  = $urandom_range(0, 99);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
      case ($urandom_range(0, 2))
        0: begin
          rx = $urandom_range(1, 40);
          ry = $urandom_range(1, 40);
        end
        1: begin
          rx = $urandom_range(40, 3000);
          ry = $urandom_range(40, 3000);
        end
        default: begin
          rx = $urandom_range(3000, 32767);
          ry = $urandom_range(3000, 32767);
        end
      endcase
      ox = $urandom_range(0, 65535 - 2 * rx);
      ox = ox - 32768 + rx;
      oy = $urandom_range(0, 65535 - 2 * ry);
      oy = oy - 32768 + ry;
      if (pick < 55) begin
        make_ring(ox, oy, rx, ry, n, 1);
        emit_shape(1'b0);
      end else if (pick < 65) begin
        make_ring(ox, oy, rx, ry, n, 1);
        emit_shape(1'b1);
      end else if (pick < 72) begin
        // star: stride two over an odd ring
        if (n % 2 == 0) n++;
        if (n < 5) n = 5;
        make_ring(ox, oy, rx, ry, n, 2);
        emit_shape(1'b0);
      end else if (pick < 85) begin
        make_ring(ox, oy, rx, ry, n, 1);
        k = $urandom_range(0, shape_x.size() - 1);
        case ($urandom_range(0, 3))
          0: begin
            shape_x.insert(k, shape_x[k]);
            shape_y.insert(k, shape_y[k]);
          end
          1: begin
            shape_x[k] = rnd16();
            shape_y[k] = rnd16();
          end
          2: begin
            t = shape_x[k]; shape_x[k] = shape_x[(k + 1) % n]; shape_x[(k + 1) % n] = t;
            t = shape_y[k]; shape_y[k] = shape_y[(k + 1) % n]; shape_y[(k + 1) % n] = t;
          end
          default: begin
            shape_x.push_back(shape_x[0]);
            shape_y.push_back(shape_y[0]);
          end
        endcase
        emit_shape(1'b0);
      end else begin
        // noise, sometimes on a tiny grid so points coincide
        n = $urandom_range(1, 6);
        t = $urandom_range(0, 1);
        for (k = 0; k < n; k++) begin
          if (t) put(rnd16(), rnd16(), k == n - 1);
          else put($urandom_range(0, 3) - 2, $urandom_range(0, 3) - 2, k == n - 1);
        end
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || vtx_bus.valid) @(negedge clk);
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatches == 0) begin
      $display("convex_polygon_check test passed");
    end else begin
      $display("convex_polygon_check test failed");
    end
    $finish;
  end

  // Vertex driver: holds a word until taken, then idles for its gap
  always @(negedge clk) begin
    vertex_word_t w;
    if (!rst) begin
      if (vtx_bus.valid && !vtx_taken) begin
        // still waiting for ready
      end else if (send_wait > 0) begin
        vtx_bus.valid <= 1'b0;
        send_wait = send_wait - 1;
      end else if (pending_q.size() != 0) begin
        w = pending_q.pop_front();
        vtx_bus.valid        <= 1'b1;
        vtx_bus.vx           <= w.x;
        vtx_bus.vy           <= w.y;
        vtx_bus.final_vertex <= w.fin;
        send_wait = w.gap;
      end else begin
        vtx_bus.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall after each word, one long hold, a stretch with none
  always @(negedge clk) begin
    if (!rst) begin
      if (res_taken) begin
        if (results_seen == HOLD_AT) stall_left = HOLD_CYCLES;
        else if (results_seen >= 40 && results_seen < 60) stall_left = 0;
        else stall_left = $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Handshake monitor: predicts on vertex words, checks result words
  always @(posedge clk) begin
    bit want;
    if (rst) begin
      vtx_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      vtx_taken <= vtx_bus.valid && vtx_bus.ready;
      res_taken <= res_bus.valid && res_bus.ready;
      if (vtx_bus.valid && vtx_bus.ready)
        predict_vertex(vtx_bus.vx, vtx_bus.vy, vtx_bus.final_vertex);
      if (res_bus.valid && res_bus.ready) begin
        results_seen <= results_seen + 1;
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none, got is_convex=%0b",
                   $time, res_bus.is_convex);
        end else begin
          want = verdict_q.pop_front();
          if (res_bus.is_convex !== want) begin
            mismatches++;
            $display("%0t: is_convex mismatch, expected %0b, got %0b",
                     $time, want, res_bus.is_convex);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #400000;
    $display("convex_polygon_check test failed");
    $finish;
  end

endmodule
